// File: rtl/plc_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and types for the positional list store.
// No dependencies; every other file imports this package.
package plc_pkg;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned DATA_WIDTH = 32;

  // Fixed field widths of the channels
  localparam int unsigned OPCODE_W  = 3;
  localparam int unsigned POS_W     = 5;
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned COUNT_O_W = 5;

  // Derived widths
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  // Opcodes
  localparam logic [OPCODE_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_REMOVE = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_READ   = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_WRITE  = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_CLEAR  = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

  // Broadcast to every cell of the row
  typedef struct packed {
    logic                  ins;
    logic                  rem;
    logic                  wr;
    logic [IDX_W-1:0]      idx;
    logic [DATA_WIDTH-1:0] wdata;
  } cell_ctrl_t;

endpackage

// File: rtl/plc_in_if.sv
`timescale 1ns / 1ps
// Request channel of the positional list store: valid/ready plus operation fields.
// Depends on plc_pkg for field widths.
interface plc_in_if
  import plc_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [POS_W-1:0]    position;
  logic [VALUE_W-1:0]  value;

  modport source (output valid, output opcode, output position, output value, input ready);
  modport sink   (input valid, input opcode, input position, input value, output ready);
endinterface

// File: rtl/plc_out_if.sv
`timescale 1ns / 1ps
// Result channel of the positional list store: valid/ready plus result fields.
// Depends on plc_pkg for field widths.
interface plc_out_if
  import plc_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [VALUE_W-1:0]   read_value;
  logic [COUNT_O_W-1:0] entry_count;
  logic                 is_empty;

  modport source (output valid, output status, output read_value, output entry_count,
                  output is_empty, input ready);
  modport sink   (input valid, input status, input read_value, input entry_count,
                  input is_empty, output ready);
endinterface

// File: rtl/plc_cell.sv
`timescale 1ns / 1ps
// One storage cell of the list row: holds one entry, shifts from its neighbours.
// Depends on plc_pkg (cell_ctrl_t, widths).
module plc_cell
  import plc_pkg::*;
(
  input  logic                  clk_i,
  input  cell_ctrl_t            ctrl_i,
  input  logic [IDX_W-1:0]      idx_i,
  input  logic [DATA_WIDTH-1:0] left_i,
  input  logic [DATA_WIDTH-1:0] right_i,
  output logic [DATA_WIDTH-1:0] data_o
);

  logic [DATA_WIDTH-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.ins && (idx_i > ctrl_i.idx)) begin
      data_d = left_i;               // make room: advance one place up
    end else if ((ctrl_i.ins || ctrl_i.wr) && (idx_i == ctrl_i.idx)) begin
      data_d = ctrl_i.wdata;
    end else if (ctrl_i.rem && (idx_i >= ctrl_i.idx)) begin
      data_d = right_i;              // close the gap
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// File: rtl/positional_list_store.sv
`timescale 1ns / 1ps
// Positional list store: an ordered list of entries addressed by 1-based position.
// Depends on plc_pkg, plc_in_if, plc_out_if and plc_cell.
//
// Usage
//   in_i  carries one operation per item: opcode, position and value.
//   out_o returns exactly one result item per operation: status, read_value,
//         entry_count and is_empty, all reflecting the list after the operation.
//   The result is loaded into the output register as the item is taken.
//   Throughput: one item per cycle while the receiver takes each result. The
//   row of DEPTH cells updates in parallel, each cell taking its left or right
//   neighbour on insert or remove.
//   Reset (rst_ni low, asynchronous) empties the list and drops any pending
//   result; the cells themselves are not cleared, since only positions up to
//   the entry count can ever be read.
//   When the receiver stalls the result is held in the output register and
//   in_i.ready drops until it is taken; a new item is taken in the same cycle
//   the waiting result leaves.
//   Bad positions give status BADPOS, an insert into a full list gives FULL;
//   in both cases the list is left unchanged. Unused opcodes complete as no-ops.
module positional_list_store
  import plc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  plc_in_if.sink    in_i,
  plc_out_if.source out_o
);

  logic                  accept;
  logic [CNT_W-1:0]      count_q, count_d;
  logic                  out_valid_q;
  logic [STATUS_W-1:0]   status_q, status_d;
  logic [VALUE_W-1:0]    rd_q, rd_d;
  logic [COUNT_O_W-1:0]  cnt_out_q;
  logic                  empty_q;
  logic [CMP_W-1:0]      pos_ext, cnt_ext, pos_m1;
  logic                  pos_ok, pos_ok_ins, full;
  cell_ctrl_t            ctrl;
  logic [DATA_WIDTH-1:0] entry [DEPTH];

  // Hold the input while a result waits and the receiver stalls
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  // Position checks, done at a common width wide enough for both sides
  assign pos_ext    = CMP_W'(in_i.position);
  assign cnt_ext    = CMP_W'(count_q);
  assign pos_m1     = pos_ext - CMP_W'(1);
  assign pos_ok     = (pos_ext != '0) && (pos_ext <= cnt_ext);
  assign pos_ok_ins = (pos_ext != '0) && (pos_ext <= cnt_ext + CMP_W'(1));
  assign full       = (count_q == CNT_W'(DEPTH));

  always_comb begin
    status_d   = ST_DONE;
    rd_d       = '0;
    count_d    = count_q;
    ctrl.ins   = 1'b0;
    ctrl.rem   = 1'b0;
    ctrl.wr    = 1'b0;
    ctrl.idx   = pos_m1[IDX_W-1:0];
    ctrl.wdata = DATA_WIDTH'(in_i.value);
    case (in_i.opcode)
      OP_INSERT: begin
        if (!pos_ok_ins) begin
          status_d = ST_BADPOS;
        end else if (full) begin
          status_d = ST_FULL;
        end else begin
          ctrl.ins = accept;
          count_d  = count_q + CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        if (!pos_ok) begin
          status_d = ST_BADPOS;
        end else begin
          ctrl.rem = accept;
          count_d  = count_q - CNT_W'(1);
        end
      end
      OP_READ: begin
        if (!pos_ok) begin
          status_d = ST_BADPOS;
        end else begin
          rd_d = VALUE_W'(entry[pos_m1[IDX_W-1:0]]);
        end
      end
      OP_WRITE: begin
        if (!pos_ok) begin
          status_d = ST_BADPOS;
        end else begin
          ctrl.wr = accept;
        end
      end
      OP_CLEAR: begin
        count_d = '0;
      end
      default: begin
        // unused opcodes: complete with no change
      end
    endcase
  end

  // Row of cells; each takes its left neighbour on insert, its right on remove
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w, right_w;
    if (k == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = entry[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign right_w = entry[k];
    end else begin : g_mid_r
      assign right_w = entry[k+1];
    end
    plc_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .idx_i   (IDX_W'(k)),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (entry[k])
    );
  end

  // Control state: entry count and result-valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload, loaded with each accepted item
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q  <= status_d;
      rd_q      <= rd_d;
      cnt_out_q <= COUNT_O_W'(count_d);
      empty_q   <= (count_d == '0);
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = status_q;
  assign out_o.read_value  = rd_q;
  assign out_o.entry_count = cnt_out_q;
  assign out_o.is_empty    = empty_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count above capacity");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.ins |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("insert did not advance the count");

  a_reject_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (status_d != ST_DONE) |=> count_q == $past(count_q))
    else $error("rejected item changed the count");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (status_q == ST_FULL) |-> full)
    else $error("full status with room left");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> empty_q == (count_q == '0))
    else $error("empty flag disagrees with count");
`endif

endmodule
